// ----- hw/rtl/etot_pkg.sv -----
package etot_pkg;

  localparam int PRIME_LIMIT = 16384;
  localparam int VALUE_W     = 14;
  localparam int DATA_W      = 16;
  localparam int ADDR_W      = $clog2(PRIME_LIMIT);
  localparam int P_W         = ADDR_W + 1;
  localparam int SQ_W        = 2 * P_W;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int UPC_W       = 4;

  // microprogram addresses
  localparam logic [UPC_W-1:0] ADR_JCLR   = 4'd0;
  localparam logic [UPC_W-1:0] ADR_FILL   = 4'd1;
  localparam logic [UPC_W-1:0] ADR_PSET   = 4'd2;
  localparam logic [UPC_W-1:0] ADR_RDP    = 4'd3;
  localparam logic [UPC_W-1:0] ADR_JSQR   = 4'd4;
  localparam logic [UPC_W-1:0] ADR_MARK   = 4'd5;
  localparam logic [UPC_W-1:0] ADR_PINC   = 4'd6;
  localparam logic [UPC_W-1:0] ADR_FINISH = 4'd7;
  localparam logic [UPC_W-1:0] ADR_IDLE   = 4'd8;
  localparam logic [UPC_W-1:0] ADR_LOOP   = 4'd9;
  localparam logic [UPC_W-1:0] ADR_SCAN   = 4'd10;
  localparam logic [UPC_W-1:0] ADR_DFIRST = 4'd11;
  localparam logic [UPC_W-1:0] ADR_DVLOOP = 4'd12;
  localparam logic [UPC_W-1:0] ADR_RSTART = 4'd13;
  localparam logic [UPC_W-1:0] ADR_DRLOOP = 4'd14;
  localparam logic [UPC_W-1:0] ADR_RUPD   = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_JCLR,
    OP_FILL,
    OP_PSET,
    OP_RDP,
    OP_JSQR,
    OP_MARK,
    OP_PINC,
    OP_EMIT,
    OP_TAKE,
    OP_RDINIT,
    OP_SCAN,
    OP_DSTEP,
    OP_RSTART,
    OP_RUPD
  } op_e;

  typedef enum logic [3:0] {
    C_TRUE,
    C_JLAST,
    C_PSQ,
    C_RDZERO,
    C_JEND,
    C_INFIRE,
    C_OUTFREE,
    C_PEND,
    C_SKIP,
    C_DLAST,
    C_REMNZ
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic             jump_if;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t rom_word(input logic [UPC_W-1:0] adr);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_TRUE, jump_if: 1'b0, target: ADR_JCLR};
    unique case (adr)
      ADR_JCLR:   w = '{op: OP_JCLR,   cond: C_TRUE,    jump_if: 1'b0, target: ADR_JCLR};
      ADR_FILL:   w = '{op: OP_FILL,   cond: C_JLAST,   jump_if: 1'b0, target: ADR_FILL};
      ADR_PSET:   w = '{op: OP_PSET,   cond: C_TRUE,    jump_if: 1'b0, target: ADR_JCLR};
      ADR_RDP:    w = '{op: OP_RDP,    cond: C_PSQ,     jump_if: 1'b1, target: ADR_IDLE};
      ADR_JSQR:   w = '{op: OP_JSQR,   cond: C_RDZERO,  jump_if: 1'b1, target: ADR_PINC};
      ADR_MARK:   w = '{op: OP_MARK,   cond: C_JEND,    jump_if: 1'b0, target: ADR_MARK};
      ADR_PINC:   w = '{op: OP_PINC,   cond: C_TRUE,    jump_if: 1'b1, target: ADR_RDP};
      ADR_FINISH: w = '{op: OP_EMIT,   cond: C_OUTFREE, jump_if: 1'b0, target: ADR_FINISH};
      ADR_IDLE:   w = '{op: OP_TAKE,   cond: C_INFIRE,  jump_if: 1'b0, target: ADR_IDLE};
      ADR_LOOP:   w = '{op: OP_RDINIT, cond: C_PEND,    jump_if: 1'b1, target: ADR_FINISH};
      ADR_SCAN:   w = '{op: OP_SCAN,   cond: C_SKIP,    jump_if: 1'b1, target: ADR_SCAN};
      ADR_DFIRST: w = '{op: OP_DSTEP,  cond: C_PEND,    jump_if: 1'b1, target: ADR_FINISH};
      ADR_DVLOOP: w = '{op: OP_DSTEP,  cond: C_DLAST,   jump_if: 1'b0, target: ADR_DVLOOP};
      ADR_RSTART: w = '{op: OP_RSTART, cond: C_REMNZ,   jump_if: 1'b1, target: ADR_LOOP};
      ADR_DRLOOP: w = '{op: OP_DSTEP,  cond: C_DLAST,   jump_if: 1'b0, target: ADR_DRLOOP};
      ADR_RUPD:   w = '{op: OP_RUPD,   cond: C_TRUE,    jump_if: 1'b1, target: ADR_LOOP};
      default:    w = '{op: OP_NOP,    cond: C_TRUE,    jump_if: 1'b0, target: ADR_JCLR};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/euler_totient.sv -----
// the prime scan walks the table, one entry a cycle while it skips non-primes; each
//   prime up to value goes through the two-bit-a-cycle shared divider for the remainder
//   and, when that is zero, again for the quotient of the running totient
// throughput: one value at a time; the next is taken once the result sits in the output register
// reset: the sieve refills the prime table before the first transfer
module euler_totient (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [etot_pkg::DATA_W-1:0] s_axis_tdata_i,  // value[13:0]
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [etot_pkg::DATA_W-1:0] m_axis_tdata_o   // totient[13:0]
);
  import etot_pkg::*;

  logic [UPC_W-1:0]   upc_q, upc_d;
  ctrl_t              ctrl;
  logic               cond_val;

  logic [VALUE_W-1:0] v_q, v_d;
  logic [VALUE_W-1:0] r_q, r_d;
  logic [P_W-1:0]     p_q, p_d;
  logic [P_W-1:0]     j_q, j_d;
  logic [VALUE_W-1:0] num_q, num_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               flags_q [PRIME_LIMIT];
  logic               rd_q;
  logic               mem_we, mem_wdata, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;

  logic [P_W-1:0]     p_next;
  logic [SQ_W-1:0]    p_sq;
  logic [P_W:0]       j_sum;
  logic               p_end, p_next_end, in_fire, out_free;
  logic [VALUE_W-1:0] num_t, rem_t, quo_t;

  assign ctrl       = rom_word(upc_q);
  assign p_next     = p_q + P_W'(1);
  assign p_sq       = SQ_W'(p_q) * SQ_W'(p_q);
  assign j_sum      = {1'b0, j_q} + {1'b0, p_q};
  assign p_end      = (p_q > {1'b0, v_q}) || (p_q >= P_W'(PRIME_LIMIT));
  assign p_next_end = (p_next > {1'b0, v_q}) || (p_next >= P_W'(PRIME_LIMIT));
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (ctrl.op == OP_TAKE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(DATA_W-VALUE_W){1'b0}}, out_q};

  // restoring divider, two quotient bits a cycle
  always_comb begin
    logic [VALUE_W:0] sh;
    rem_t = rem_q;
    num_t = num_q;
    quo_t = quo_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      sh    = {rem_t, num_t[VALUE_W-1]};
      num_t = {num_t[VALUE_W-2:0], 1'b0};
      if (sh >= {1'b0, p_q[VALUE_W-1:0]}) begin
        rem_t = VALUE_W'(sh - {1'b0, p_q[VALUE_W-1:0]});
        quo_t = {quo_t[VALUE_W-2:0], 1'b1};
      end else begin
        rem_t = sh[VALUE_W-1:0];
        quo_t = {quo_t[VALUE_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    unique case (ctrl.cond)
      C_TRUE:    cond_val = 1'b1;
      C_JLAST:   cond_val = (j_q == P_W'(PRIME_LIMIT - 1));
      C_PSQ:     cond_val = (p_sq >= SQ_W'(PRIME_LIMIT));
      C_RDZERO:  cond_val = !rd_q;
      C_JEND:    cond_val = (j_sum >= (P_W+1)'(PRIME_LIMIT));
      C_INFIRE:  cond_val = in_fire;
      C_OUTFREE: cond_val = out_free;
      C_PEND:    cond_val = p_end;
      C_SKIP:    cond_val = !rd_q && !p_next_end;
      C_DLAST:   cond_val = (cnt_q == CNT_W'(DIV_STEPS - 1));
      C_REMNZ:   cond_val = (rem_q != '0);
      default:   cond_val = 1'b0;
    endcase
    upc_d = (cond_val == ctrl.jump_if) ? ctrl.target : upc_q + UPC_W'(1);
  end

  always_comb begin
    v_d       = v_q;
    r_d       = r_q;
    p_d       = p_q;
    j_d       = j_q;
    num_d     = num_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_waddr = j_q[ADDR_W-1:0];
    mem_re    = 1'b0;
    mem_raddr = p_q[ADDR_W-1:0];
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (ctrl.op)
      OP_NOP: ;
      OP_JCLR: j_d = '0;
      OP_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (j_q >= P_W'(2));
        j_d       = j_q + P_W'(1);
      end
      OP_PSET: p_d = P_W'(2);
      OP_RDP:  mem_re = 1'b1;
      OP_JSQR: j_d = p_sq[P_W-1:0];
      OP_MARK: begin
        mem_we = 1'b1;
        j_d    = j_sum[P_W-1:0];
      end
      OP_PINC: p_d = p_next;
      OP_EMIT: begin
        if (out_free) begin
          out_d       = r_q;
          out_valid_d = 1'b1;
        end
      end
      OP_TAKE: begin
        v_d = s_axis_tdata_i[VALUE_W-1:0];
        r_d = s_axis_tdata_i[VALUE_W-1:0];
        p_d = P_W'(2);
      end
      OP_RDINIT: begin
        mem_re = 1'b1;
        num_d  = v_q;
        rem_d  = '0;
        quo_d  = '0;
        cnt_d  = '0;
      end
      OP_SCAN: begin
        if (!rd_q) begin
          p_d       = p_next;
          mem_re    = 1'b1;
          mem_raddr = p_next[ADDR_W-1:0];
          num_d     = v_q;
          rem_d     = '0;
          quo_d     = '0;
          cnt_d     = '0;
        end else begin
          num_d = num_t;
          rem_d = rem_t;
          quo_d = quo_t;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_DSTEP: begin
        num_d = num_t;
        rem_d = rem_t;
        quo_d = quo_t;
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_RSTART: begin
        if (rem_q != '0) begin
          p_d = p_next;
        end else begin
          num_d = r_q;
          rem_d = '0;
          quo_d = '0;
          cnt_d = '0;
        end
      end
      OP_RUPD: begin
        r_d = r_q - quo_q;
        p_d = p_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ADR_JCLR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    p_q   <= p_d;
    j_q   <= j_d;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  // prime flag table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flags_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= flags_q[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_r_le_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q >= ADR_LOOP) |-> (r_q <= v_q))
    else $error("totient exceeds value");

  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_MARK) |-> (j_q < P_W'(PRIME_LIMIT)))
    else $error("sieve mark beyond table");

  a_exact_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_RUPD) |-> (rem_q == '0))
    else $error("inexact division of running totient");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_EMIT && out_free) |=>
      (m_axis_tvalid_o && (m_axis_tdata_o[VALUE_W-1:0] == $past(r_q))))
    else $error("result not loaded into output register");
`endif

endmodule
